/* sv/ipv6_to_ipv4_address_map_assert.svh */
// Assertion macros used by the address map datapath.
// No dependencies; include by bare file name.
`ifndef IPV6_TO_IPV4_ADDRESS_MAP_ASSERT_SVH
`define IPV6_TO_IPV4_ADDRESS_MAP_ASSERT_SVH

// same-cycle implication
`define AM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("address map assertion failed");

// next-cycle implication
`define AM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("address map assertion failed");

`endif

/* sv/v6v4m_pkg.sv */
// Types and constants of the IPv6/IPv4 address map.
// No dependencies; used by the top level, controller and datapath.
package v6v4m_pkg;

   localparam int TABLE_DEPTH      = 256;
   localparam int ENDING_W         = $clog2(TABLE_DEPTH);
   localparam int ENDING_CAP       = TABLE_DEPTH - 1;
   localparam int MAX_MAPPINGS_DEF = 255;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_V4_PREFIX      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_V4_PREFIX_MASK = 1'd1;

   localparam logic FUNC_V6_TO_V4  = 1'b0;
   localparam logic FUNC_V4_TO_V6  = 1'b1;
   localparam logic STATUS_SUCCESS = 1'b0;
   localparam logic STATUS_FAIL    = 1'b1;

   localparam logic [31:0] V4_PREFIX_RST      = 32'h6440_0000;
   localparam logic [31:0] V4_PREFIX_MASK_RST = 32'hFFFF_FF00;
   localparam logic [15:0] V4_MAPPED_TAG      = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SCAN,
      ST_ALLOC,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_MAPPED4,
      RES_V4MAPPED,
      RES_HIT,
      RES_ALLOC,
      RES_FAIL
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        scan_start;
      logic        scan_step;
      logic        alloc;
      logic        load_result;
      res_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic zero6;
      logic mapped6;
      logic zero4;
      logic outside4;
      logic hit;
      logic scan_done;
      logic full;
   } stat_type;

   typedef struct packed {
      logic [63:0] upper;
      logic [63:0] lower;
      logic [31:0] scope;
   } entry_type;

endpackage

/* sv/v6v4m_if.sv */
// Request and response channel interfaces of the address map.
// Depends on nothing; used by the top level.
interface v6v4m_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] v4_addr;
   logic [63:0] v6_upper;
   logic [63:0] v6_lower;
   logic [31:0] v6_scope;

   modport source (output valid, func, v4_addr, v6_upper, v6_lower, v6_scope,
                   input ready);
   modport sink   (input valid, func, v4_addr, v6_upper, v6_lower, v6_scope,
                   output ready);
endinterface

interface v6v4m_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] v4_result;
   logic [63:0] v6_upper_out;
   logic [63:0] v6_lower_out;
   logic [31:0] scope_out;

   modport source (output valid, status, v4_result, v6_upper_out, v6_lower_out,
                   scope_out, input ready);
   modport sink   (input valid, status, v4_result, v6_upper_out, v6_lower_out,
                   scope_out, output ready);
endinterface

/* sv/ipv6_to_ipv4_address_map.sv */
// Zero, mapped and outside-prefix words go from classify straight to the response state;
// table lookups scan the allocated entries, of which there are at most 255.
// The key scan reads one entry per cycle through a single registered memory port.
// A new word is accepted once the last response is loaded, also while that response waits.
// Reset restores the prefix registers and empties the table by clearing the entry count;
// the key memory is not cleared and no clearing pass runs.
module ipv6_to_ipv4_address_map
   import v6v4m_pkg::*;
#(
   parameter int MAX_MAPPINGS = MAX_MAPPINGS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   v6v4m_req_if.sink             req_chan,
   v6v4m_rsp_if.source           rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   v6v4m_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   v6v4m_dp #(
      .MAX_MAPPINGS (MAX_MAPPINGS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_func         (req_chan.func),
      .req_v4_addr      (req_chan.v4_addr),
      .req_v6_upper     (req_chan.v6_upper),
      .req_v6_lower     (req_chan.v6_lower),
      .req_v6_scope     (req_chan.v6_scope),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_chan.status),
      .rsp_v4_result    (rsp_chan.v4_result),
      .rsp_v6_upper_out (rsp_chan.v6_upper_out),
      .rsp_v6_lower_out (rsp_chan.v6_lower_out),
      .rsp_scope_out    (rsp_chan.scope_out)
   );

endmodule

/* sv/v6v4m_ctrl.sv */
// Controller state machine of the address map: sequences classify, scan,
// allocate and response. Depends on v6v4m_pkg.
module v6v4m_ctrl
   import v6v4m_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type   state_ff, state_in;
   res_sel_type sel_ff, sel_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            state_in = ST_RESP;
            if (stat.func == FUNC_V6_TO_V4) begin
               if (stat.zero6)        sel_in = RES_ZERO;
               else if (stat.mapped6) sel_in = RES_MAPPED4;
               else                   state_in = ST_SCAN;
            end else begin
               if (stat.zero4)         sel_in = RES_ZERO;
               else if (stat.outside4) sel_in = RES_V4MAPPED;
               else                    state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               state_in = ST_RESP;
               sel_in   = RES_HIT;
            end else if (stat.scan_done) begin
               if ((stat.func == FUNC_V4_TO_V6) || stat.full) begin
                  state_in = ST_RESP;
                  sel_in   = RES_FAIL;
               end else begin
                  state_in = ST_ALLOC;
               end
            end
         end
         ST_ALLOC: begin
            state_in = ST_RESP;
            sel_in   = RES_ALLOC;
         end
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.sel         = sel_ff;
      req_ready       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CLASSIFY: cmd.scan_start = 1'b1;
         ST_SCAN:     cmd.scan_step  = !stat.hit;
         ST_ALLOC:    cmd.alloc      = 1'b1;
         ST_RESP:     cmd.load_result = out_free;
         default:     cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) rsp_valid_in = 1'b1;
      else if (rsp_ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= RES_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/v6v4m_dp.sv */
// Datapath of the address map: request and config registers, key memory,
// scan counter, compare and response registers. Depends on v6v4m_pkg.
module v6v4m_dp
   import v6v4m_pkg::*;
#(
   parameter int MAX_MAPPINGS = MAX_MAPPINGS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_func,
   input  logic [31:0]           req_v4_addr,
   input  logic [63:0]           req_v6_upper,
   input  logic [63:0]           req_v6_lower,
   input  logic [31:0]           req_v6_scope,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  rsp_status,
   output logic [31:0]           rsp_v4_result,
   output logic [63:0]           rsp_v6_upper_out,
   output logic [63:0]           rsp_v6_lower_out,
   output logic [31:0]           rsp_scope_out
);

`include "ipv6_to_ipv4_address_map_assert.svh"

   localparam int LIMIT_INT = (MAX_MAPPINGS > ENDING_CAP) ? ENDING_CAP : MAX_MAPPINGS;
   localparam logic [ENDING_W-1:0] LIMIT = ENDING_W'(LIMIT_INT);

   logic [31:0]         prefix_ff, mask_ff;
   logic                func_ff;
   logic [31:0]         v4_addr_ff;
   entry_type           key_ff;
   logic [ENDING_W-1:0] next_ending_ff;
   logic [ENDING_W:0]   cnt_ff;
   logic                rd_valid_ff;
   logic [ENDING_W-1:0] tag_ff;
   entry_type           rd_data_ff;
   entry_type           key_mem_ff [TABLE_DEPTH];
   logic                status_ff;
   logic [31:0]         v4_result_ff;
   entry_type           out_ff;

   logic                issue;
   logic [ENDING_W-1:0] alloc_idx;
   logic [31:0]         tag_addr;
   logic                match;
   logic                status_in;
   logic [31:0]         v4_result_in;
   entry_type           out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= V4_PREFIX_RST;
         mask_ff   <= V4_PREFIX_MASK_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_V4_PREFIX:      prefix_ff <= csr_wdata;
            CSR_V4_PREFIX_MASK: mask_ff   <= csr_wdata;
            default:            prefix_ff <= prefix_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff      <= req_func;
         v4_addr_ff   <= req_v4_addr;
         key_ff.upper <= req_v6_upper;
         key_ff.lower <= req_v6_lower;
         key_ff.scope <= req_v6_scope;
      end
   end

   assign issue     = cmd.scan_step && (cnt_ff <= {1'b0, next_ending_ff});
   assign alloc_idx = next_ending_ff + ENDING_W'(1);
   assign tag_addr  = prefix_ff | {{(32-ENDING_W){1'b0}}, tag_ff};
   assign match     = (func_ff == FUNC_V4_TO_V6) ? (tag_addr == v4_addr_ff)
                                                 : (rd_data_ff == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ending_ff <= '0;
         cnt_ff         <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (cmd.alloc) next_ending_ff <= alloc_idx;
         if (cmd.scan_start) begin
            cnt_ff <= (ENDING_W+1)'(1);
         end else if (issue) begin
            cnt_ff <= cnt_ff + (ENDING_W+1)'(1);
         end
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) key_mem_ff[alloc_idx] <= key_ff;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= key_mem_ff[cnt_ff[ENDING_W-1:0]];
         tag_ff     <= cnt_ff[ENDING_W-1:0];
      end
   end

   always_comb begin
      stat.func      = func_ff;
      stat.zero6     = (key_ff.upper == 64'd0) && (key_ff.lower == 64'd0);
      stat.mapped6   = (key_ff.upper == 64'd0) && (key_ff.lower[63:32] == {16'd0, V4_MAPPED_TAG});
      stat.zero4     = (v4_addr_ff == 32'd0);
      stat.outside4  = ((v4_addr_ff & mask_ff) != (prefix_ff & mask_ff));
      stat.hit       = rd_valid_ff && match;
      stat.scan_done = !rd_valid_ff && (cnt_ff > {1'b0, next_ending_ff});
      stat.full      = (next_ending_ff >= LIMIT);
   end

   always_comb begin
      status_in    = STATUS_SUCCESS;
      v4_result_in = 32'd0;
      out_in       = '0;
      case (cmd.sel)
         RES_ZERO:     status_in = STATUS_SUCCESS;
         RES_MAPPED4:  v4_result_in = key_ff.lower[31:0];
         RES_V4MAPPED: out_in.lower = {16'd0, V4_MAPPED_TAG, v4_addr_ff};
         RES_HIT: begin
            if (func_ff == FUNC_V4_TO_V6) out_in = rd_data_ff;
            else                          v4_result_in = tag_addr;
         end
         RES_ALLOC:    v4_result_in = prefix_ff | {{(32-ENDING_W){1'b0}}, next_ending_ff};
         RES_FAIL:     status_in = STATUS_FAIL;
         default:      status_in = STATUS_FAIL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         status_ff    <= status_in;
         v4_result_ff <= v4_result_in;
         out_ff       <= out_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_v4_result    = v4_result_ff;
   assign rsp_v6_upper_out = out_ff.upper;
   assign rsp_v6_lower_out = out_ff.lower;
   assign rsp_scope_out    = out_ff.scope;

   `AM_ASSERT_NOW(a_alloc_has_room, clock, reset, cmd.alloc, next_ending_ff < LIMIT)
   `AM_ASSERT_NEXT(a_alloc_counts, clock, reset, cmd.alloc, next_ending_ff == $past(alloc_idx))
   `AM_ASSERT_NOW(a_read_in_range, clock, reset, rd_valid_ff, (tag_ff != '0) && (tag_ff <= next_ending_ff))
   `AM_ASSERT_NOW(a_hit_not_done, clock, reset, stat.hit, !stat.scan_done)

endmodule
